@@ sv/cidt_pkg.sv @@
// Package for the CAN identifier history and delay tracker.
// Holds the request and response types, kind codes and parameter defaults.
// No dependencies.
package cidt_pkg;

  localparam int IdW       = 29;
  localparam int StatedW   = 30;
  localparam int NumStated = 4;
  localparam int CfgIdxW   = 2;

  localparam logic [StatedW-1:0] StatedReset = 30'd536870912;

  localparam int TrackedIdsDef   = 64;
  localparam int HistoryDepthDef = 8;
  localparam int DelayDef        = 4;

  localparam logic [1:0] KindFrame   = 2'd0;
  localparam logic [1:0] KindAnomAdd = 2'd1;
  localparam logic [1:0] KindAnomDel = 2'd2;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] can_id;
    logic [3:0]     bus_id;
    logic [63:0]    timestamp;
    logic [63:0]    payload;
    logic [3:0]     length;
  } in_req_t;

  typedef struct packed {
    logic        delayed_valid;
    logic [3:0]  delayed_bus;
    logic [63:0] delayed_timestamp;
    logic [63:0] delayed_payload;
    logic [3:0]  delayed_length;
    logic        in_report_set;
    logic        table_full;
  } out_rsp_t;

endpackage

@@ sv/cidt_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cidt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/can_id_history_delay_tracker.sv @@
// A request is accepted in idle, then S entry-table words are scanned (S is 1 up to the identifiers
// in use), the entry is written when one is matched or added, and the result register loads in the
// finish state once the output is not stalled. One request at a time, set by the linear scan of the
// entry RAM; the next request is accepted once the block is back in idle after the result loads.
// Reset clears control state and the fill count and sets the stated identifiers to a value that
// matches no identifier; no clearing pass. Depends on cidt_pkg and cidt_ram.
module can_id_history_delay_tracker #(
  parameter int TRACKED_IDS   = cidt_pkg::TrackedIdsDef,
  parameter int HISTORY_DEPTH = cidt_pkg::HistoryDepthDef,
  parameter int DELAY         = cidt_pkg::DelayDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  cidt_pkg::in_req_t                      in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output cidt_pkg::out_rsp_t                     out_rsp_o,
  input  logic                                   cfg_we_i,
  input  logic [cidt_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [cidt_pkg::StatedW-1:0]           cfg_data_i
);
  import cidt_pkg::*;

  localparam int IdxW     = (TRACKED_IDS > 1) ? $clog2(TRACKED_IDS) : 1;
  localparam int FillW    = $clog2(TRACKED_IDS + 1);
  localparam int HeadW    = $clog2(HISTORY_DEPTH);
  localparam int CntW     = $clog2(HISTORY_DEPTH + 1);
  localparam int EntW     = IdW + CntW + HeadW + 1;
  localparam int HDepth   = TRACKED_IDS * HISTORY_DEPTH;
  localparam int HAddrW   = $clog2(HDepth);
  localparam int HistW    = 4 + 64 + 64 + 4;
  localparam int DelayMod = DELAY % HISTORY_DEPTH;

  localparam logic [FillW-1:0] FillMax  = FillW'(TRACKED_IDS);
  localparam logic [CntW-1:0]  CntMax   = CntW'(HISTORY_DEPTH);
  localparam logic [HeadW-1:0] HeadLast = HeadW'(HISTORY_DEPTH - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  logic [StatedW-1:0] stated_q [NumStated];

  in_req_t            req_q, req_d;
  out_rsp_t           out_q, out_d;
  logic [IdxW-1:0]    scan_q, scan_d;
  logic [IdxW-1:0]    ent_idx_q, ent_idx_d;
  logic [CntW-1:0]    ent_cnt_q, ent_cnt_d;
  logic [HeadW-1:0]   ent_head_q, ent_head_d;
  logic               ent_rep_q, ent_rep_d;
  logic               res_dvalid_q, res_dvalid_d;
  logic               res_rep_q, res_rep_d;
  logic               res_full_q, res_full_d;

  logic [IdxW-1:0]    ent_raddr;
  logic [EntW-1:0]    ent_rdata, ent_wdata;
  logic               ent_we;
  logic [IdW-1:0]     rd_id;
  logic [CntW-1:0]    rd_cnt;
  logic [HeadW-1:0]   rd_head;
  logic               rd_rep;

  logic [HAddrW-1:0]  hist_base, hist_waddr, hist_raddr;
  logic [HistW-1:0]   hist_wdata, hist_rdata;
  logic               hist_we;

  logic               scan_kind, match, last, stated;
  logic [CntW-1:0]    cnt_new;
  logic [HeadW-1:0]   head_new, pos;
  logic               dvalid, rep_new;

  always_comb begin
    stated = 1'b0;
    for (int i = 0; i < NumStated; i++) begin
      if (stated_q[i] == {1'b0, req_q.can_id}) begin
        stated = 1'b1;
      end
    end
  end

  assign {rd_id, rd_cnt, rd_head, rd_rep} = ent_rdata;

  assign scan_kind = (req_q.kind == KindFrame) || (req_q.kind == KindAnomAdd) ||
                     (req_q.kind == KindAnomDel);
  assign match     = (fill_q != '0) && (rd_id == req_q.can_id);
  assign last      = (fill_q == '0) || ((FillW'(scan_q) + FillW'(1)) == fill_q);
  assign ent_raddr = (state_q == StScan) ? scan_q + IdxW'(1) : '0;

  assign head_new = (ent_head_q == HeadLast) ? '0 : ent_head_q + HeadW'(1);
  assign cnt_new  = (ent_cnt_q == CntMax) ? ent_cnt_q : ent_cnt_q + CntW'(1);
  assign dvalid   = int'(cnt_new) > DELAY;
  assign rep_new  = ent_rep_q | (dvalid & stated);
  assign pos      = (int'(ent_head_q) >= DelayMod) ?
                    HeadW'(int'(ent_head_q) - DelayMod) :
                    HeadW'(int'(ent_head_q) + HISTORY_DEPTH - DelayMod);

  assign hist_base  = HAddrW'(ent_idx_q) * HAddrW'(HISTORY_DEPTH);
  assign hist_waddr = hist_base + HAddrW'(ent_head_q);
  assign hist_raddr = hist_base + HAddrW'(pos);
  assign hist_wdata = {req_q.bus_id, req_q.timestamp, req_q.payload, req_q.length};
  assign hist_we    = (state_q == StUpdate) && (req_q.kind == KindFrame);

  assign ent_we = (state_q == StUpdate);

  always_comb begin
    if (req_q.kind == KindFrame) begin
      ent_wdata = {req_q.can_id, cnt_new, head_new, rep_new};
    end else begin
      ent_wdata = {req_q.can_id, ent_cnt_q, ent_head_q,
                   stated ? ent_rep_q : (req_q.kind == KindAnomAdd)};
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q & out_stall_i;
    req_d        = req_q;
    out_d        = out_q;
    scan_d       = scan_q;
    ent_idx_d    = ent_idx_q;
    ent_cnt_d    = ent_cnt_q;
    ent_head_d   = ent_head_q;
    ent_rep_d    = ent_rep_q;
    res_dvalid_d = res_dvalid_q;
    res_rep_d    = res_rep_q;
    res_full_d   = res_full_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          scan_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        res_dvalid_d = 1'b0;
        res_rep_d    = 1'b0;
        res_full_d   = 1'b0;
        if (!scan_kind) begin
          state_d = StFinish;
        end else if (match) begin
          ent_idx_d  = scan_q;
          ent_cnt_d  = rd_cnt;
          ent_head_d = rd_head;
          ent_rep_d  = rd_rep;
          state_d    = StUpdate;
        end else if (last) begin
          if (req_q.kind != KindFrame) begin
            state_d = StFinish;
          end else if (fill_q == FillMax) begin
            res_full_d = 1'b1;
            state_d    = StFinish;
          end else begin
            ent_idx_d  = fill_q[IdxW-1:0];
            ent_cnt_d  = '0;
            ent_head_d = '0;
            ent_rep_d  = 1'b0;
            fill_d     = fill_q + FillW'(1);
            state_d    = StUpdate;
          end
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      StUpdate: begin
        if (req_q.kind == KindFrame) begin
          res_dvalid_d = dvalid;
          res_rep_d    = rep_new;
        end else begin
          res_dvalid_d = 1'b0;
          res_rep_d    = stated ? ent_rep_q : (req_q.kind == KindAnomAdd);
        end
        state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = '0;
          out_d.in_report_set = res_rep_q;
          out_d.table_full    = res_full_q;
          if (res_dvalid_q) begin
            out_d.delayed_valid = 1'b1;
            if (DELAY == 0) begin
              out_d.delayed_bus       = req_q.bus_id;
              out_d.delayed_timestamp = req_q.timestamp;
              out_d.delayed_payload   = req_q.payload;
              out_d.delayed_length    = req_q.length;
            end else begin
              {out_d.delayed_bus, out_d.delayed_timestamp,
               out_d.delayed_payload, out_d.delayed_length} = hist_rdata;
            end
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumStated; i++) begin
        stated_q[i] <= StatedReset;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        stated_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    out_q        <= out_d;
    scan_q       <= scan_d;
    ent_idx_q    <= ent_idx_d;
    ent_cnt_q    <= ent_cnt_d;
    ent_head_q   <= ent_head_d;
    ent_rep_q    <= ent_rep_d;
    res_dvalid_q <= res_dvalid_d;
    res_rep_q    <= res_rep_d;
    res_full_q   <= res_full_d;
  end

  cidt_ram #(
    .Width (EntW),
    .Depth (TRACKED_IDS),
    .AddrW (IdxW)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_idx_q),
    .wdata_i (ent_wdata),
    .re_i    (1'b1),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  cidt_ram #(
    .Width (HistW),
    .Depth (HDepth),
    .AddrW (HAddrW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_we),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
